// ===== design/sfd_pkg.sv =====
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared types and constants for the serial frame deframer.
// ----------------------------------------------------------------------------
package sfd_pkg;

    // Width of the configuration address bus (three 32-bit registers).
    localparam int ADDR_W = 4;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] REG_SYNC_VALUE   = 2'd0;
    localparam logic [1:0] REG_EXPECTED_ID  = 2'd1;
    localparam logic [1:0] REG_LENGTH_LIMIT = 2'd2;

    // Register reset values.
    localparam logic [7:0] SYNC_RESET  = 8'hAA;
    localparam logic [7:0] ID_RESET    = 8'h00;
    localparam logic [7:0] LIMIT_RESET = 8'd250;

    // Number of result words, four bytes each.
    localparam int NUM_WORDS = 4;

    // Payload position within a group of four that feeds the checksum.
    localparam logic [1:0] SUM_LANE = 2'd2;

    // Parser phases.
    typedef enum logic [2:0] {
        PH_SYNC  = 3'd0,
        PH_ID    = 3'd1,
        PH_LEN   = 3'd2,
        PH_DATA  = 3'd3,
        PH_CHECK = 3'd4
    } phase_t;

    // Configuration values handed to the parser.
    typedef struct packed {
        logic [7:0] sync_value;
        logic [7:0] expected_id;
        logic [7:0] length_limit;
    } sfd_cfg_t;

    // One result item.
    typedef struct packed {
        logic                         frame_good;
        logic [NUM_WORDS-1:0][31:0]   words;
    } sfd_result_t;

endpackage

// ===== design/sfd_regs.sv =====
// ----------------------------------------------------------------------------
// sfd_regs
// APB-style configuration registers: sync value, expected ID, length limit.
// ----------------------------------------------------------------------------
module sfd_regs (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [sfd_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output sfd_pkg::sfd_cfg_t          cfg
);
    import sfd_pkg::*;

    logic [7:0] sync_reg;
    logic [7:0] id_reg;
    logic [7:0] limit_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    // Register writes; addresses past the list are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_reg  <= SYNC_RESET;
            id_reg    <= ID_RESET;
            limit_reg <= LIMIT_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                REG_SYNC_VALUE:   sync_reg  <= pwdata[7:0];
                REG_EXPECTED_ID:  id_reg    <= pwdata[7:0];
                REG_LENGTH_LIMIT: limit_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Read decode.
    always_comb begin
        unique case (reg_idx)
            REG_SYNC_VALUE:   prdata = {24'd0, sync_reg};
            REG_EXPECTED_ID:  prdata = {24'd0, id_reg};
            REG_LENGTH_LIMIT: prdata = {24'd0, limit_reg};
            default:          prdata = 32'd0;
        endcase
    end

    assign cfg.sync_value   = sync_reg;
    assign cfg.expected_id  = id_reg;
    assign cfg.length_limit = limit_reg;

endmodule

// ===== design/sfd_parser.sv =====
// ----------------------------------------------------------------------------
// sfd_parser
// Frame state machine, running checksum and payload byte store.
// ----------------------------------------------------------------------------
module sfd_parser #(
    parameter int STORED_BYTES = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step,
    input  logic [7:0]           rx_byte,
    input  sfd_pkg::sfd_cfg_t    cfg,
    output logic                 result_valid,
    output sfd_pkg::sfd_result_t result
);
    import sfd_pkg::*;

    localparam int IDX_W = $clog2(STORED_BYTES);
    localparam logic [7:0] STORE_DEPTH = 8'(STORED_BYTES);

    phase_t     phase_reg, phase_next;
    logic [7:0] left_reg, left_next;
    logic [7:0] pos_reg, pos_next;
    logic [7:0] sum_reg, sum_next;
    logic [7:0] store_reg [STORED_BYTES];
    logic       store_we;
    logic [7:0] left_dec;

    assign left_dec = left_reg - 8'd1;

    // Next phase.
    always_comb begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_SYNC:  if (rx_byte == cfg.sync_value) phase_next = PH_ID;
            PH_ID:    phase_next = (rx_byte == cfg.expected_id) ? PH_LEN : PH_SYNC;
            PH_LEN: begin
                if (rx_byte < cfg.length_limit) begin
                    phase_next = (rx_byte == 8'd0) ? PH_CHECK : PH_DATA;
                end else begin
                    phase_next = PH_SYNC;
                end
            end
            PH_DATA:  if (left_dec == 8'd0) phase_next = PH_CHECK;
            PH_CHECK: phase_next = PH_SYNC;
            default:  phase_next = PH_SYNC;
        endcase
    end

    // Counters, checksum, store write and result flag.
    always_comb begin
        left_next    = left_reg;
        pos_next     = pos_reg;
        sum_next     = sum_reg;
        store_we     = 1'b0;
        result_valid = 1'b0;
        unique case (phase_reg)
            PH_SYNC: begin
                if (rx_byte == cfg.sync_value) sum_next = rx_byte;
            end
            PH_ID: begin
                sum_next = sum_reg + rx_byte;
            end
            PH_LEN: begin
                if (rx_byte < cfg.length_limit) begin
                    left_next = rx_byte;
                    pos_next  = 8'd0;
                    sum_next  = sum_reg + rx_byte;
                end
            end
            PH_DATA: begin
                store_we  = (pos_reg < STORE_DEPTH);
                if (pos_reg[1:0] == SUM_LANE) sum_next = sum_reg + rx_byte;
                pos_next  = pos_reg + 8'd1;
                left_next = left_dec;
            end
            PH_CHECK: begin
                result_valid = step;
                sum_next     = 8'd0;
            end
            default: ;
        endcase
    end

    // State registers advance only when an item is processed.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_SYNC;
            left_reg  <= 8'd0;
            pos_reg   <= 8'd0;
            sum_reg   <= 8'd0;
        end else if (step) begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
            pos_reg   <= pos_next;
            sum_reg   <= sum_next;
        end
    end

    // Payload store, cleared at reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < STORED_BYTES; i++) store_reg[i] <= 8'd0;
        end else if (step && store_we) begin
            store_reg[pos_reg[IDX_W-1:0]] <= rx_byte;
        end
    end

    // Result words; bytes past the store read as zero.
    always_comb begin
        result.frame_good = (rx_byte == sum_reg);
        result.words      = '0;
        for (int w = 0; w < NUM_WORDS; w++) begin
            for (int j = 0; j < 4; j++) begin
                if (w * 4 + j < STORED_BYTES) begin
                    result.words[w][j*8 +: 8] = store_reg[w * 4 + j];
                end
            end
        end
    end

endmodule

// ===== design/serial_frame_deframer_top.sv =====
// ----------------------------------------------------------------------------
// serial_frame_deframer_top
// Serial frame deframer: sync, ID, length, payload and checksum parsing.
// ----------------------------------------------------------------------------
// Usage:
//   Received bytes enter on the s_ channel (s_valid, s_ready, s_rx_byte), one
//   item per byte. A frame is a sync byte, an ID byte, a length byte, the
//   payload and a checksum byte. When the checksum byte has been parsed, one
//   result item leaves on the m_ channel carrying m_frame_good and the first
//   sixteen payload bytes as four little-endian words.
//   Each byte is captured in an input register and parsed by the frame state
//   machine once the output register can take a result. The result of a
//   checksum byte is registered in the output register, which drives m_valid.
//   One byte is taken every cycle while the output is not stalled; the state
//   machine updates phase, counters and checksum per byte, which sets the rate.
//   When the receiver stalls, the result waits in the output register and the
//   input register still takes one more byte; non-result bytes keep flowing
//   only while no result is pending behind a stalled output.
//   Synchronous reset (aresetn low) returns to sync hunt, clears the checksum,
//   the counters and the payload store, empties both registers and restores
//   the configuration defaults. The user must write the configuration over
//   the APB port only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module serial_frame_deframer_top #(
    parameter int STORED_BYTES = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [sfd_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [7:0]                 s_rx_byte,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_frame_good,
    output logic [31:0]                m_word_one,
    output logic [31:0]                m_word_two,
    output logic [31:0]                m_word_three,
    output logic [31:0]                m_word_four
);
    import sfd_pkg::*;

    sfd_cfg_t    cfg;
    sfd_result_t result;
    logic        result_valid;
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        out_valid_reg;
    sfd_result_t out_reg;
    logic        advance;

    // Configuration registers.
    sfd_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The held byte is parsed whenever the output register can take a result.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    // Frame parser.
    sfd_parser #(
        .STORED_BYTES (STORED_BYTES)
    ) u_parser (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (advance),
        .rx_byte      (in_byte_reg),
        .cfg          (cfg),
        .result_valid (result_valid),
        .result       (result)
    );

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (result_valid) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (result_valid) begin
            out_reg <= result;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_frame_good = out_reg.frame_good;
    assign m_word_one   = out_reg.words[0];
    assign m_word_two   = out_reg.words[1];
    assign m_word_three = out_reg.words[2];
    assign m_word_four  = out_reg.words[3];

endmodule

// ===== design/sfd_checker.sv =====
// ----------------------------------------------------------------------------
// sfd_checker
// Port-level checks for the serial frame deframer, bound to the top level.
// ----------------------------------------------------------------------------
module sfd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_frame_good,
    input logic [31:0] m_word_one,
    input logic [31:0] m_word_four
);

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result item pending after reset");

    // A stalled result item holds its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_frame_good) &&
        $stable(m_word_one) && $stable(m_word_four))
        else $error("stalled result item changed");

    // A new result follows an accepted input item.
    a_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 2))
        else $error("result item without a preceding input item");

    // A receiver that is ready never blocks the input side.
    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled while output is ready");

endmodule

bind serial_frame_deframer_top sfd_checker u_sfd_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_frame_good (m_frame_good),
    .m_word_one   (m_word_one),
    .m_word_four  (m_word_four)
);

// ===== bench/serial_frame_deframer_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// serial_frame_deframer_top_tb
// Self-checking bench for the serial frame deframer. Bytes are sent one item
// at a time over the s_ channel. A parser model inside the bench follows the
// same sync, ID, length, payload and checksum phases and queues the frame
// result that each checksum byte should produce. Results on the m_ channel
// are compared against that queue field by field. Registers are set over APB
// between traffic phases and read back. Both channels idle at random.
// ----------------------------------------------------------------------------
module serial_frame_deframer_top_tb;
    import sfd_pkg::*;

    localparam int STORE_N     = 16;
    localparam int STORE_IDX_W = $clog2(STORE_N);
    localparam int DRAIN_CYC   = 8;
    localparam int CYCLE_LIMIT = 300000;
    localparam int SHOW_MAX    = 10;

    logic                aclk;
    logic                aresetn;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;
    logic                s_valid;
    logic                s_ready;
    logic [7:0]          s_rx_byte;
    logic                m_valid;
    logic                m_ready;
    logic                m_frame_good;
    logic [31:0]         m_word_one;
    logic [31:0]         m_word_two;
    logic [31:0]         m_word_three;
    logic [31:0]         m_word_four;

    // Parser model state and its copy of the registers.
    logic [7:0]          cfg_sync;
    logic [7:0]          cfg_id;
    logic [7:0]          cfg_limit;
    phase_t              rx_phase;
    logic [7:0]          rx_left;
    logic [7:0]          rx_pos;
    logic [7:0]          rx_sum;
    logic [7:0]          rx_store [STORE_N];
    sfd_result_t         frames_due [$];

    bit                  idle_on;
    int unsigned         mismatch_count;
    int unsigned         cycle_count;
    sfd_result_t         due;
    logic [31:0]         seen_words [NUM_WORDS];

    serial_frame_deframer_top dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_rx_byte    (s_rx_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_frame_good (m_frame_good),
        .m_word_one   (m_word_one),
        .m_word_two   (m_word_two),
        .m_word_three (m_word_three),
        .m_word_four  (m_word_four)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Watchdog on the total run length.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("serial_frame_deframer_top_tb NOT OK");
        $finish;
    end

    task automatic log_mismatch(input string what, input logic [31:0] want,
                                input logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= SHOW_MAX) begin
            $display("mismatch at %0t: %s expected %h got %h", $realtime, what, want, got);
        end
    endtask

    // Advance the parser model by one accepted byte and queue any frame result.
    task automatic parse_byte(input logic [7:0] b);
        sfd_result_t r;
        case (rx_phase)
            PH_SYNC: begin
                if (b == cfg_sync) begin
                    rx_sum   = b;
                    rx_phase = PH_ID;
                end
            end
            PH_ID: begin
                rx_sum   = rx_sum + b;
                rx_phase = (b == cfg_id) ? PH_LEN : PH_SYNC;
            end
            PH_LEN: begin
                if (b < cfg_limit) begin
                    rx_left  = b;
                    rx_pos   = 8'd0;
                    rx_sum   = rx_sum + b;
                    rx_phase = (b == 8'd0) ? PH_CHECK : PH_DATA;
                end else begin
                    rx_phase = PH_SYNC;
                end
            end
            PH_DATA: begin
                if (rx_pos < STORE_N) begin
                    rx_store[rx_pos[STORE_IDX_W-1:0]] = b;
                end
                if (rx_pos[1:0] == SUM_LANE) begin
                    rx_sum = rx_sum + b;
                end
                rx_pos  = rx_pos + 8'd1;
                rx_left = rx_left - 8'd1;
                if (rx_left == 8'd0) begin
                    rx_phase = PH_CHECK;
                end
            end
            PH_CHECK: begin
                r.frame_good = (b == rx_sum);
                for (int k = 0; k < NUM_WORDS; k++) begin
                    r.words[k] = {rx_store[4*k+3], rx_store[4*k+2],
                                  rx_store[4*k+1], rx_store[4*k]};
                end
                frames_due.push_back(r);
                rx_sum   = 8'd0;
                rx_phase = PH_SYNC;
            end
            default: begin
                rx_phase = PH_SYNC;
            end
        endcase
    endtask

    // Send one byte item; called and left at a falling edge.
    task automatic push_byte(input logic [7:0] b);
        int unsigned gap;
        gap = idle_on ? $urandom_range(0, 10) : 0;
        if (gap != 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   = 1'b1;
        s_rx_byte = b;
        do @(posedge aclk); while (!s_ready);
        parse_byte(b);
        @(negedge aclk);
    endtask

    // Stop sending and wait until every queued frame result has come out.
    task automatic wait_frames_done();
        s_valid = 1'b0;
        while (frames_due.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    // As above, then let the pipeline empty of bytes that give no result.
    task automatic settle();
        wait_frames_done();
        repeat (DRAIN_CYC) @(negedge aclk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [7:0] val);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = {24'h0, val};
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic apb_check(input logic [1:0] idx, input logic [7:0] want);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = {idx, 2'b00};
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata[7:0] !== want) begin
            log_mismatch("register readback", {24'h0, want}, {24'h0, prdata[7:0]});
        end
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // Write all three registers while idle, then read them back.
    task automatic set_config(input logic [7:0] sync_v, input logic [7:0] id_v,
                              input logic [7:0] limit_v);
        settle();
        apb_write(REG_SYNC_VALUE, sync_v);
        apb_write(REG_EXPECTED_ID, id_v);
        apb_write(REG_LENGTH_LIMIT, limit_v);
        cfg_sync  = sync_v;
        cfg_id    = id_v;
        cfg_limit = limit_v;
        apb_check(REG_SYNC_VALUE, cfg_sync);
        apb_check(REG_EXPECTED_ID, cfg_id);
        apb_check(REG_LENGTH_LIMIT, cfg_limit);
    endtask

    // One well-formed frame with random payload; good selects the checksum.
    task automatic send_frame(input logic [7:0] len, input bit good);
        logic [7:0] sum;
        logic [7:0] pay;
        int         i;
        sum = cfg_sync + cfg_id + len;
        push_byte(cfg_sync);
        push_byte(cfg_id);
        push_byte(len);
        for (i = 0; i < len; i++) begin
            pay = 8'($urandom);
            if ((i % 4) == 2) begin
                sum = sum + pay;
            end
            push_byte(pay);
        end
        push_byte(good ? sum : sum ^ (8'd1 << $urandom_range(0, 7)));
    endtask

    // Mostly short lengths, now and then anything the limit allows.
    function automatic logic [7:0] pick_length();
        int upper;
        upper = int'(cfg_limit) - 1;
        if ($urandom_range(0, 19) == 0) begin
            return 8'($urandom_range(0, upper));
        end
        return 8'($urandom_range(0, (upper < 20) ? upper : 20));
    endfunction

    // Mixed traffic: mostly valid frames, plus broken frames and noise.
    task automatic random_traffic(input int unsigned items);
        int unsigned sent;
        int unsigned pick;
        logic [7:0]  len;
        sent = 0;
        while (sent < items) begin
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
                len = pick_length();
                send_frame(len, pick < 68);
                sent += 4 + len;
            end else if (pick < 86) begin
                push_byte(cfg_sync);
                push_byte(cfg_id ^ 8'($urandom_range(1, 255)));
                sent += 2;
            end else if (pick < 92) begin
                push_byte(cfg_sync);
                push_byte(cfg_id);
                push_byte(8'($urandom_range(cfg_limit, 255)));
                sent += 3;
            end else if (pick < 98) begin
                push_byte(8'($urandom));
            end else begin
                wait_frames_done();
            end
        end
    endtask

    task automatic test_register_defaults();
        apb_check(REG_SYNC_VALUE, SYNC_RESET);
        apb_check(REG_EXPECTED_ID, ID_RESET);
        apb_check(REG_LENGTH_LIMIT, LIMIT_RESET);
    endtask

    task automatic test_directed_frames();
        logic [7:0] seq [$];
        seq = '{
            // Zero length with the right checksum, store still cleared.
            8'hAA, 8'h00, 8'h00, 8'hAA,
            // Short frame of extreme bytes with a wrong checksum.
            8'hAA, 8'h00, 8'h03, 8'hFF, 8'h00, 8'hFF, 8'h00,
            // Wrong ID, then a length at the limit.
            8'hAA, 8'h01,
            8'hAA, 8'h00, 8'hFA,
            // A stray byte during sync hunt.
            8'h55,
            // One-byte frame: later store bytes keep the previous payload.
            8'hAA, 8'h00, 8'h01, 8'h80, 8'hAB
        };
        foreach (seq[i]) begin
            push_byte(seq[i]);
        end
    endtask

    task automatic test_default_traffic();
        random_traffic(300);
    endtask

    task automatic test_wide_limit();
        set_config(8'h00, 8'hFF, 8'd255);
        send_frame(8'd254, 1'b1);
        random_traffic(200);
    endtask

    task automatic test_narrow_limit();
        set_config(8'hFF, 8'h80, 8'd1);
        random_traffic(120);
    endtask

    task automatic test_random_settings();
        for (int round = 0; round < 3; round++) begin
            set_config(8'($urandom), 8'($urandom), 8'($urandom_range(1, 255)));
            idle_on = (round != 1);
            random_traffic(130);
        end
        idle_on = 1'b1;
    endtask

    // Result checker: every accepted result against the oldest frame due.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (frames_due.size() == 0) begin
                log_mismatch("result with no frame due", 32'h0, {31'h0, m_frame_good});
            end else begin
                due = frames_due.pop_front();
                seen_words[0] = m_word_one;
                seen_words[1] = m_word_two;
                seen_words[2] = m_word_three;
                seen_words[3] = m_word_four;
                if (m_frame_good !== due.frame_good) begin
                    log_mismatch("frame_good", {31'h0, due.frame_good}, {31'h0, m_frame_good});
                end
                for (int k = 0; k < NUM_WORDS; k++) begin
                    if (seen_words[k] !== due.words[k]) begin
                        log_mismatch($sformatf("word %0d", k), due.words[k], seen_words[k]);
                    end
                end
            end
        end
    end

    // Receiver: a random stall before each result item.
    initial begin : result_sink
        int unsigned stall;
        m_ready = 1'b0;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            stall = idle_on ? $urandom_range(0, 10) : 0;
            if (stall != 0) begin
                m_ready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
        end
    end

    initial begin
        aresetn        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        s_valid        = 1'b0;
        s_rx_byte      = 8'h00;
        idle_on        = 1'b1;
        mismatch_count = 0;
        cfg_sync       = SYNC_RESET;
        cfg_id         = ID_RESET;
        cfg_limit      = LIMIT_RESET;
        rx_phase       = PH_SYNC;
        rx_left        = 8'd0;
        rx_pos         = 8'd0;
        rx_sum         = 8'd0;
        foreach (rx_store[i]) rx_store[i] = 8'h00;

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_register_defaults();
        test_directed_frames();
        test_default_traffic();
        test_wide_limit();
        test_narrow_limit();
        test_random_settings();

        settle();
        if (mismatch_count == 0) begin
            $display("serial_frame_deframer_top_tb OK");
        end else begin
            $display("serial_frame_deframer_top_tb NOT OK");
        end
        $finish;
    end

endmodule
